### rtl/core/spt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spt_pkg
// Shared types, widths and codes for the shortest path tree core.
// ---------------------------------------------------------------------------
package spt_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int VTX_W  = 10;
    localparam int EDGE_W = 12;
    localparam int VCNT_W = 11;
    localparam int ECNT_W = 13;
    localparam int WGT_W  = 32;
    localparam int DIST_W = 48;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NEGLOOP = 2'd2;

    localparam logic [1:0] KIND_PARENT = 2'd0;
    localparam logic [1:0] KIND_SOURCE = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    localparam logic [1:0] MODE_FWD = 2'd0;
    localparam logic [1:0] MODE_REV = 2'd1;

    localparam logic [1:0] REG_VCOUNT = 2'd0;
    localparam logic [1:0] REG_ECOUNT = 2'd1;
    localparam logic [1:0] REG_DIR    = 2'd2;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_GT  = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic signed [DIST_W-1:0] vdist;
        logic                     reached;
        logic [ECNT_W-1:0]        parent;
        logic                     clean;
        logic [VCNT_W-1:0]        tq;
    } t_vstate;

    typedef struct packed {
        logic [VTX_W-1:0]        from;
        logic [VTX_W-1:0]        to;
        logic signed [WGT_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic clr_we;
        logic init;
        logic push;
        logic pop;
        logic flush;
    } t_fifo_ctl;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic [1:0]               parent_kind;
        logic [VTX_W-1:0]         parent_vertex;
        logic [EDGE_W-1:0]        inbound_edge;
    } t_result;

endpackage
`default_nettype wire

### rtl/core/spt_alu.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spt_alu
// Shared distance unit: saturating 48-bit add or signed greater-than.
// ---------------------------------------------------------------------------
module spt_alu import spt_pkg::*; (
    input  t_alu_op                  i_op,
    input  logic signed [DIST_W-1:0] i_a,
    input  logic signed [DIST_W-1:0] i_b,
    output logic signed [DIST_W-1:0] o_y
);

    logic signed [DIST_W:0] sum;

    always_comb begin
        sum = {i_a[DIST_W-1], i_a} + {i_b[DIST_W-1], i_b};
        unique case (i_op)
            ALU_ADD: begin
                if (sum[DIST_W] != sum[DIST_W-1]) begin
                    o_y = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
                                      : {1'b0, {(DIST_W-1){1'b1}}};
                end else begin
                    o_y = sum[DIST_W-1:0];
                end
            end
            ALU_GT: begin
                o_y = {{(DIST_W-1){1'b0}}, (i_a > i_b)};
            end
            default: o_y = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/spt_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spt_fifo
// Work queue of vertices with registered read, bulk init and flush.
// ---------------------------------------------------------------------------
module spt_fifo import spt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_ctl         i_ctl,
    input  logic [VTX_W-1:0]  i_clr_addr,
    input  logic [VTX_W-1:0]  i_push_data,
    input  logic [VCNT_W-1:0] i_init_fill,
    output logic [VTX_W-1:0]  o_rdata,
    output logic [VCNT_W-1:0] o_fill
);

    logic [VTX_W-1:0]  r_mem [MAX_VERTICES];
    logic [VTX_W-1:0]  r_head;
    logic [VTX_W-1:0]  r_tail;
    logic [VCNT_W-1:0] r_fill;
    logic [VTX_W-1:0]  r_rdata;
    logic              push_ok;

    assign push_ok = i_ctl.push && (r_fill < VCNT_W'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_we) begin
            r_mem[i_clr_addr] <= i_clr_addr;
        end else if (push_ok) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_rdata <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_ctl.flush) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_ctl.init) begin
            r_head <= '0;
            r_tail <= i_init_fill[VTX_W-1:0];
            r_fill <= i_init_fill;
        end else if (i_ctl.pop) begin
            r_head <= r_head + 1'b1;
            r_fill <= r_fill - 1'b1;
        end else if (push_ok) begin
            r_tail <= r_tail + 1'b1;
            r_fill <= r_fill + 1'b1;
        end
    end

    assign o_rdata = r_rdata;
    assign o_fill  = r_fill;

endmodule
`default_nettype wire

### rtl/core/shortest_path_tree_negative_weights_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// shortest_path_tree_negative_weights_core
// Queue-based Bellman-Ford shortest path tree over a loaded edge table.
//
// Request channel i_valid/o_stall carries cmd, edge fields and vertex; the
// result channel o_valid/i_stall carries one result per request.
// Load requests write the edge table and are taken one per cycle while
// i_stall is low. Query requests read the vertex state, then the edge
// table, then register the result. Run requests clear the vertex store
// and queue, seed the source, then per popped vertex read its state and,
// for a reached vertex, scan every edge slot and compare and update the
// far end of each incident edge; a result closes the run. The single
// vertex store read port and the shared add/compare unit set this pace.
// After reset a pass clearing the vertex store and queue runs with o_stall
// high; configuration writes over the APB port are taken at all times.
// The result register holds while i_stall is high; a new request is taken
// only when the result register is free or drains in the same cycle.
// ---------------------------------------------------------------------------
module shortest_path_tree_negative_weights_core import spt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_cmd,
    input  logic [EDGE_W-1:0]        i_edge_index,
    input  logic [VTX_W-1:0]         i_edge_from,
    input  logic [VTX_W-1:0]         i_edge_to,
    input  logic signed [WGT_W-1:0]  i_edge_weight,
    input  logic [VTX_W-1:0]         i_vertex,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic signed [DIST_W-1:0] o_distance,
    output logic                     o_reachable,
    output logic [1:0]               o_parent_kind,
    output logic [VTX_W-1:0]         o_parent_vertex,
    output logic [EDGE_W-1:0]        o_inbound_edge,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_QV    = 14'b00000000000100,
        S_QOUT  = 14'b00000000001000,
        S_RCLR  = 14'b00000000010000,
        S_RSRC  = 14'b00000000100000,
        S_POP   = 14'b00000001000000,
        S_POPD  = 14'b00000010000000,
        S_VJ    = 14'b00000100000000,
        S_EADDR = 14'b00001000000000,
        S_EDATA = 14'b00010000000000,
        S_VT    = 14'b00100000000000,
        S_CMP   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [VCNT_W-1:0] r_vc;
    logic [ECNT_W-1:0] r_ec;
    logic [1:0]        r_dm;

    logic [VTX_W-1:0]        r_cnt;
    logic [VTX_W-1:0]        r_src;
    logic                    r_neg;
    logic [VTX_W-1:0]        r_j;
    logic signed [DIST_W-1:0] r_dj;
    logic [ECNT_W-1:0]       r_e;
    logic [VTX_W-1:0]        r_tgt;
    logic signed [WGT_W-1:0] r_w;
    t_vstate                 r_vt;
    t_vstate                 r_vs;
    logic signed [DIST_W-1:0] r_alt;
    logic [VTX_W-1:0]        r_qv;
    logic                    r_ovalid;
    t_result                 r_res;

    t_vstate r_vmem [MAX_VERTICES];
    t_vstate r_vrd;
    t_edge   r_emem [MAX_EDGES];
    t_edge   r_erd;

    logic              vwe;
    logic [VTX_W-1:0]  vwaddr;
    t_vstate           vwdata;
    logic [VTX_W-1:0]  vraddr;
    logic [EDGE_W-1:0] eraddr;
    logic              ewe;

    t_fifo_ctl         fctl;
    logic [VTX_W-1:0]  f_rdata;
    logic [VCNT_W-1:0] f_fill;

    t_alu_op                  alu_op;
    logic signed [DIST_W-1:0] alu_a;
    logic signed [DIST_W-1:0] alu_b;
    logic signed [DIST_W-1:0] alu_y;

    logic [VCNT_W-1:0] eff_n;
    logic [ECNT_W-1:0] eff_m;
    logic [1:0]        eff_mode;
    logic              accept;
    logic              out_free;
    logic              out_load;
    t_result           n_res;
    logic              vtx_ok;
    logic [VCNT_W-1:0] tq_inc;
    logic              e_hit;
    logic [VTX_W-1:0]  e_tgt;
    logic              better;
    logic              cfg_we;
    logic [ECNT_W-1:0] e_next;

    assign eff_n = (r_vc == '0) ? VCNT_W'(1) :
                   (r_vc > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vc;
    assign eff_m = (r_ec > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : r_ec;
    assign eff_mode = (r_dm == 2'd3) ? 2'd2 : r_dm;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign vtx_ok   = {1'b0, i_vertex} < eff_n;
    assign tq_inc   = r_vrd.tq + VCNT_W'(1);
    assign e_next   = r_e + ECNT_W'(1);
    assign ewe      = accept && (i_cmd == CMD_LOAD);

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_VCOUNT: prdata = {{(32-VCNT_W){1'b0}}, r_vc};
            REG_ECOUNT: prdata = {{(32-ECNT_W){1'b0}}, r_ec};
            REG_DIR:    prdata = {30'd0, r_dm};
            default:    prdata = '0;
        endcase
    end

    // edge selection for the vertex being expanded
    always_comb begin
        e_hit = 1'b0;
        e_tgt = r_erd.to;
        if (({1'b0, r_erd.from} < eff_n) && ({1'b0, r_erd.to} < eff_n)) begin
            if (eff_mode == MODE_FWD) begin
                e_hit = (r_erd.from == r_j);
                e_tgt = r_erd.to;
            end else if (eff_mode == MODE_REV) begin
                e_hit = (r_erd.to == r_j);
                e_tgt = r_erd.from;
            end else if (r_erd.from == r_j) begin
                e_hit = 1'b1;
                e_tgt = r_erd.to;
            end else if (r_erd.to == r_j) begin
                e_hit = 1'b1;
                e_tgt = r_erd.from;
            end
        end
    end

    spt_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign better = !r_vt.reached || alu_y[0];

    spt_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fctl),
        .i_clr_addr  (r_cnt),
        .i_push_data (r_tgt),
        .i_init_fill (eff_n),
        .o_rdata     (f_rdata),
        .o_fill      (f_fill)
    );

    always_comb begin
        n_state  = r_state;
        vwe      = 1'b0;
        vwaddr   = r_tgt;
        vwdata   = '0;
        vraddr   = i_vertex;
        eraddr   = r_e[EDGE_W-1:0];
        fctl     = '0;
        alu_op   = ALU_ADD;
        alu_a    = r_dj;
        alu_b    = DIST_W'(r_w);
        out_load = 1'b0;
        n_res    = '0;
        unique case (r_state)
            S_INIT, S_RCLR: begin
                vwe         = 1'b1;
                vwaddr      = r_cnt;
                fctl.clr_we = 1'b1;
                if (r_cnt == {VTX_W{1'b1}}) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_RSRC;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_LOAD) begin
                        out_load     = 1'b1;
                        n_res.status = ST_OK;
                    end else if ((i_cmd == CMD_RUN || i_cmd == CMD_QUERY) && vtx_ok) begin
                        n_state = (i_cmd == CMD_RUN) ? S_RCLR : S_QV;
                    end else begin
                        out_load     = 1'b1;
                        n_res.status = ST_RANGE;
                    end
                end
            end
            S_QV: begin
                eraddr  = EDGE_W'(r_vrd.parent - ECNT_W'(1));
                n_state = S_QOUT;
            end
            S_QOUT: begin
                n_res.status      = r_neg ? ST_NEGLOOP : ST_OK;
                n_res.parent_kind = KIND_NONE;
                if (r_vs.reached) begin
                    if (r_qv == r_src) begin
                        n_res.distance    = r_vs.vdist;
                        n_res.reachable   = 1'b1;
                        n_res.parent_kind = KIND_SOURCE;
                    end else if (r_vs.parent != '0) begin
                        n_res.distance      = r_vs.vdist;
                        n_res.reachable     = 1'b1;
                        n_res.parent_kind   = KIND_PARENT;
                        n_res.parent_vertex = (r_erd.to == r_qv) ? r_erd.from : r_erd.to;
                        n_res.inbound_edge  = EDGE_W'(r_vs.parent - ECNT_W'(1));
                    end
                end
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RSRC: begin
                vwe            = 1'b1;
                vwaddr         = r_src;
                vwdata.reached = 1'b1;
                fctl.init      = 1'b1;
                n_state        = S_POP;
            end
            S_POP: begin
                if (f_fill == '0) begin
                    n_state = S_DONE;
                end else begin
                    fctl.pop = 1'b1;
                    n_state  = S_POPD;
                end
            end
            S_POPD: begin
                vraddr  = f_rdata;
                n_state = S_VJ;
            end
            S_VJ: begin
                vwe          = 1'b1;
                vwaddr       = r_j;
                vwdata       = r_vrd;
                vwdata.clean = 1'b1;
                vwdata.tq    = tq_inc;
                if (tq_inc > eff_n) begin
                    fctl.flush = 1'b1;
                    n_state    = S_DONE;
                end else if (!r_vrd.reached) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_EADDR;
                end
            end
            S_EADDR: begin
                n_state = (r_e >= eff_m) ? S_POP : S_EDATA;
            end
            S_EDATA: begin
                vraddr  = e_tgt;
                n_state = e_hit ? S_VT : S_EADDR;
            end
            S_VT: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                alu_op = ALU_GT;
                alu_a  = r_vt.vdist;
                alu_b  = r_alt;
                if (better) begin
                    vwe            = 1'b1;
                    vwdata         = r_vt;
                    vwdata.vdist   = r_alt;
                    vwdata.reached = 1'b1;
                    vwdata.parent  = e_next;
                    vwdata.clean   = 1'b0;
                    fctl.push      = r_vt.clean;
                end
                n_state = S_EADDR;
            end
            S_DONE: begin
                n_res.status = r_neg ? ST_NEGLOOP : ST_OK;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vmem[vwaddr] <= vwdata;
        end
        r_vrd <= r_vmem[vraddr];
        if (ewe) begin
            r_emem[i_edge_index] <= '{from: i_edge_from, to: i_edge_to, weight: i_edge_weight};
        end
        r_erd <= r_emem[eraddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_vc     <= VCNT_W'(1);
            r_ec     <= '0;
            r_dm     <= '0;
            r_src    <= '0;
            r_neg    <= 1'b0;
            r_e      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                unique case (paddr[3:2])
                    REG_VCOUNT: r_vc <= pwdata[VCNT_W-1:0];
                    REG_ECOUNT: r_ec <= pwdata[ECNT_W-1:0];
                    REG_DIR:    r_dm <= pwdata[1:0];
                    default:    r_dm <= r_dm;
                endcase
            end
            if (r_state == S_INIT || r_state == S_RCLR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (accept && i_cmd == CMD_RUN && vtx_ok) begin
                r_src <= i_vertex;
                r_neg <= 1'b0;
                r_cnt <= '0;
            end
            if (r_state == S_VJ) begin
                r_e <= '0;
                if (tq_inc > eff_n) begin
                    r_neg <= 1'b1;
                end
            end
            if (r_state == S_CMP || (r_state == S_EDATA && !e_hit)) begin
                r_e <= e_next;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qv <= i_vertex;
        end
        if (r_state == S_QV) begin
            r_vs <= r_vrd;
        end
        if (r_state == S_POPD) begin
            r_j <= f_rdata;
        end
        if (r_state == S_VJ) begin
            r_dj <= r_vrd.vdist;
        end
        if (r_state == S_EDATA) begin
            r_tgt <= e_tgt;
            r_w   <= r_erd.weight;
        end
        if (r_state == S_VT) begin
            r_vt  <= r_vrd;
            r_alt <= alu_y;
        end
        if (r_state == S_CMP && better && r_tgt == r_j) begin
            r_dj <= r_alt;
        end
        if (out_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_res.status;
    assign o_distance      = r_res.distance;
    assign o_reachable     = r_res.reachable;
    assign o_parent_kind   = r_res.parent_kind;
    assign o_parent_vertex = r_res.parent_vertex;
    assign o_inbound_edge  = r_res.inbound_edge;

`ifndef SYNTHESIS
    a_negloop_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VJ && tq_inc > eff_n) |=> (r_neg && r_state == S_DONE))
        else $error("negative loop not flagged");

    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDATA) |-> (r_e < eff_m))
        else $error("edge scan beyond edge count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_fill <= VCNT_W'(MAX_VERTICES))
        else $error("work queue overfilled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_ovalid || !i_stall))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
